/* hw/rtl/pdsd_pkg.sv */
package pdsd_pkg;

    // stream payload widths, padded to whole bytes
    localparam int IN_W  = 56;
    localparam int OUT_W = 64;
    localparam int CFG_W = 64;
    localparam int CFG_IDX_W = 3;

    // shared multiplier operand widths
    localparam int MUL_A_W = 32;
    localparam int MUL_B_W = 24;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    // shared divider: radix-16 restoring, small constant divisors
    localparam int DIV_W     = 48;
    localparam int DIV_DIGIT = 4;
    localparam int DIV_STEPS = DIV_W / DIV_DIGIT;
    localparam int STEP_W    = $clog2(DIV_STEPS);
    localparam int DIVISOR_W = 14;

    localparam logic [DIVISOR_W-1:0] DIVISOR_K2    = 14'd10;
    localparam logic [DIVISOR_W-1:0] DIVISOR_IMU   = 14'd100;
    localparam logic [DIVISOR_W-1:0] DIVISOR_TAN   = 14'd1000;
    localparam logic [DIVISOR_W-1:0] DIVISOR_SCALE = 14'd100;
    localparam logic [DIVISOR_W-1:0] DIVISOR_DELTA = 14'd10000;
    localparam logic [DIVISOR_W-1:0] DIVISOR_PWM   = 14'd3;

    localparam logic signed [MUL_B_W-1:0] TAN_NUM    = 24'sd175;
    localparam logic signed [14:0]        PWM_OFFSET = 15'sd1500;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAINS_STRAIGHT = 3'd0,
        CFG_GAINS_LEFT     = 3'd1,
        CFG_GAINS_NORMAL   = 3'd2,
        CFG_ACKERMANN      = 3'd3,
        CFG_SPEED          = 3'd4,
        CFG_ANGLE_CENTER   = 3'd5,
        CFG_ANGLE_MIN      = 3'd6,
        CFG_ANGLE_MAX      = 3'd7
    } cfg_idx_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_MKP,
        ST_MKD,
        ST_MEE,
        ST_MK2,
        ST_D10,
        ST_W10,
        ST_D100,
        ST_W100,
        ST_ANG,
        ST_MTAN,
        ST_DTAN,
        ST_WTAN,
        ST_MSC,
        ST_DSC,
        ST_WSC,
        ST_MDL,
        ST_DDL,
        ST_WDL,
        ST_DPWM,
        ST_WPWM,
        ST_FIN
    } state_t;

    typedef struct packed {
        logic                        start;
        logic signed [DIV_W-1:0]     dividend;
        logic [DIVISOR_W-1:0]        divisor;
    } div_req_t;

    typedef struct packed {
        logic                        done;
        logic signed [DIV_W-1:0]     quotient;
    } div_rsp_t;

endpackage

/* hw/rtl/pdsd_mul.sv */
module pdsd_mul import pdsd_pkg::*; (
    input  logic                       aclk,
    input  logic signed [MUL_A_W-1:0]  op_a,
    input  logic signed [MUL_B_W-1:0]  op_b,
    output logic signed [PROD_W-1:0]   prod
);

    logic signed [PROD_W-1:0] prod_reg;

    // registered signed product, one result per cycle
    always_ff @(posedge aclk) begin
        prod_reg <= PROD_W'(op_a) * PROD_W'(op_b);
    end

    assign prod = prod_reg;

endmodule

/* hw/rtl/pdsd_div.sv */
module pdsd_div import pdsd_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  div_req_t  req,
    output div_rsp_t  rsp
);

    logic                  busy_reg;
    logic                  done_reg;
    logic                  neg_reg;
    logic [STEP_W-1:0]     cnt_reg;
    logic [DIV_W-1:0]      qm_reg;
    logic [DIV_W-1:0]      qm_next;
    logic [DIVISOR_W-1:0]  rem_reg;
    logic [DIVISOR_W-1:0]  rem_next;
    logic [DIVISOR_W-1:0]  divisor_reg;
    logic [DIV_W-1:0]      mag;

    // magnitude of the dividend, quotient truncates toward zero
    assign mag = req.dividend[DIV_W-1] ? DIV_W'(-req.dividend) : DIV_W'(req.dividend);

    // four restoring steps per cycle, quotient bits shift in behind the dividend
    always_comb begin
        logic [DIVISOR_W:0]   r;
        logic [DIV_DIGIT-1:0] qd;
        r  = {1'b0, rem_reg};
        qd = '0;
        for (int i = 0; i < DIV_DIGIT; i++) begin
            r = {r[DIVISOR_W-1:0], qm_reg[DIV_W-1-i]};
            if (r >= {1'b0, divisor_reg}) begin
                r = r - {1'b0, divisor_reg};
                qd[DIV_DIGIT-1-i] = 1'b1;
            end
        end
        rem_next = r[DIVISOR_W-1:0];
        qm_next  = {qm_reg[DIV_W-DIV_DIGIT-1:0], qd};
    end

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == STEP_W'(DIV_STEPS - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (req.start) begin
            neg_reg     <= req.dividend[DIV_W-1];
            qm_reg      <= mag;
            rem_reg     <= '0;
            divisor_reg <= req.divisor;
        end else if (busy_reg) begin
            qm_reg  <= qm_next;
            rem_reg <= rem_next;
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = neg_reg ? -$signed(qm_reg) : $signed(qm_reg);

endmodule

/* hw/rtl/steering_pd_with_differential_speed_top.sv */
// a frame is accepted only in idle, and the next one only after its result is loaded
// into the output register; each frame runs six divisions on the shared radix-16
//   divider and its multiplies on the shared multiplier, one after another
// skipped frames (not ready or repeated sequence) are taken in idle and give no result
// reset: synchronous active-low aresetn clears control, state and configuration registers to defaults
module steering_pd_with_differential_speed_top import pdsd_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // lateral_error[15:0], yaw_rate[31:16], frame_ready[32], frame_seq[48:33],
    // on_straight[49], in_ring[50], on_ramp[51], stop_request[52]
    input  logic [IN_W-1:0]       s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // steer_angle[15:0], pwm_duty[30:16], left_speed[46:31], right_speed[62:47]
    output logic [OUT_W-1:0]      m_tdata,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]      cfg_data
);

    // input fields
    logic signed [15:0] in_err;
    logic signed [15:0] in_yaw;
    logic               in_frame_ready;
    logic [15:0]        in_seq;
    logic               in_straight;
    logic               in_ring;
    logic               in_ramp;
    logic               in_stop;

    assign in_err         = s_tdata[15:0];
    assign in_yaw         = s_tdata[31:16];
    assign in_frame_ready = s_tdata[32];
    assign in_seq         = s_tdata[48:33];
    assign in_straight    = s_tdata[49];
    assign in_ring        = s_tdata[50];
    assign in_ramp        = s_tdata[51];
    assign in_stop        = s_tdata[52];

    // configuration registers
    logic [63:0]        gains_straight_reg;
    logic [63:0]        gains_left_reg;
    logic [63:0]        gains_normal_reg;
    logic [47:0]        ackermann_reg;
    logic [63:0]        speed_set_reg;
    logic signed [15:0] angle_center_reg;
    logic signed [15:0] angle_min_reg;
    logic signed [15:0] angle_max_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gains_straight_reg <= '0;
            gains_left_reg     <= '0;
            gains_normal_reg   <= '0;
            ackermann_reg      <= '0;
            speed_set_reg      <= '0;
            angle_center_reg   <= '0;
            angle_min_reg      <= 16'sh8000;
            angle_max_reg      <= 16'sh7fff;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_GAINS_STRAIGHT: gains_straight_reg <= cfg_data;
                CFG_GAINS_LEFT:     gains_left_reg     <= cfg_data;
                CFG_GAINS_NORMAL:   gains_normal_reg   <= cfg_data;
                CFG_ACKERMANN:      ackermann_reg      <= cfg_data[47:0];
                CFG_SPEED:          speed_set_reg      <= cfg_data;
                CFG_ANGLE_CENTER:   angle_center_reg   <= cfg_data[15:0];
                CFG_ANGLE_MIN:      angle_min_reg      <= cfg_data[15:0];
                CFG_ANGLE_MAX:      angle_max_reg      <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // sequencer and working registers
    state_t             state_reg;
    state_t             state_next;
    logic signed [15:0] prev_err_reg;
    logic [15:0]        prev_seq_reg;
    logic signed [15:0] e_reg;
    logic signed [15:0] d_reg;
    logic signed [15:0] gyro_reg;
    logic [63:0]        gains_reg;
    logic signed [15:0] ack_reg;
    logic signed [15:0] speed_reg;
    logic signed [15:0] acc_reg;
    logic signed [15:0] angle_reg;
    logic signed [15:0] tan_reg;
    logic signed [23:0] scale_reg;
    logic signed [15:0] delta_reg;
    logic signed [14:0] pwm_reg;
    logic [OUT_W-1:0]   m_tdata_reg;
    logic               m_tvalid_reg;

    logic               accept;
    logic               frame_ok;
    logic               out_load;
    logic               straight_set;
    logic [63:0]        gains_sel;
    logic signed [15:0] ack_sel;
    logic signed [15:0] speed_sel;

    // shared units
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0]  prod;
    div_req_t                  div_req;
    div_rsp_t                  div_rsp;

    pdsd_mul u_mul (
        .aclk (aclk),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (prod)
    );

    pdsd_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    // gain fields of the selected set
    logic signed [15:0] g_kp;
    logic signed [15:0] g_kd;
    logic signed [15:0] g_k2;
    logic signed [15:0] g_imu;

    assign g_kp  = gains_reg[15:0];
    assign g_kd  = gains_reg[31:16];
    assign g_k2  = gains_reg[47:32];
    assign g_imu = gains_reg[63:48];

    // frame filter and set selection
    assign accept       = s_tvalid && s_tready;
    assign frame_ok     = in_frame_ready && (in_seq != prev_seq_reg);
    assign straight_set = in_straight && !in_ring && !in_ramp;

    always_comb begin
        if (straight_set) begin
            gains_sel = gains_straight_reg;
            ack_sel   = ackermann_reg[15:0];
        end else if (in_err[15]) begin
            gains_sel = gains_left_reg;
            ack_sel   = ackermann_reg[31:16];
        end else begin
            gains_sel = gains_normal_reg;
            ack_sel   = ackermann_reg[47:32];
        end
    end

    // base speed priority
    always_comb begin
        if (in_stop)          speed_sel = '0;
        else if (in_ramp)     speed_sel = speed_set_reg[15:0];
        else if (in_ring)     speed_sel = speed_set_reg[31:16];
        else if (in_straight) speed_sel = speed_set_reg[47:32];
        else                  speed_sel = speed_set_reg[63:48];
    end

    // angle from control, clamped
    logic signed [15:0] raw_angle;
    logic signed [15:0] clamped_angle;
    logic signed [15:0] steer;

    assign raw_angle = angle_center_reg - acc_reg;
    assign steer     = angle_center_reg - angle_reg;

    always_comb begin
        if (raw_angle < angle_min_reg)      clamped_angle = angle_min_reg;
        else if (raw_angle > angle_max_reg) clamped_angle = angle_max_reg;
        else                                clamped_angle = raw_angle;
    end

    // wheel split
    logic signed [15:0] left_speed;
    logic signed [15:0] right_speed;

    always_comb begin
        if (delta_reg <= 16'sd0) begin
            left_speed  = speed_reg + delta_reg;
            right_speed = speed_reg;
        end else begin
            left_speed  = speed_reg;
            right_speed = speed_reg - delta_reg;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (accept && frame_ok) state_next = ST_MKP;
            ST_MKP:  state_next = ST_MKD;
            ST_MKD:  state_next = ST_MEE;
            ST_MEE:  state_next = ST_MK2;
            ST_MK2:  state_next = ST_D10;
            ST_D10:  state_next = ST_W10;
            ST_W10:  if (div_rsp.done) state_next = ST_D100;
            ST_D100: state_next = ST_W100;
            ST_W100: if (div_rsp.done) state_next = ST_ANG;
            ST_ANG:  state_next = ST_MTAN;
            ST_MTAN: state_next = ST_DTAN;
            ST_DTAN: state_next = ST_WTAN;
            ST_WTAN: if (div_rsp.done) state_next = ST_MSC;
            ST_MSC:  state_next = ST_DSC;
            ST_DSC:  state_next = ST_WSC;
            ST_WSC:  if (div_rsp.done) state_next = ST_MDL;
            ST_MDL:  state_next = ST_DDL;
            ST_DDL:  state_next = ST_WDL;
            ST_WDL:  if (div_rsp.done) state_next = ST_DPWM;
            ST_DPWM: state_next = ST_WPWM;
            ST_WPWM: if (div_rsp.done) state_next = ST_FIN;
            ST_FIN:  if (out_load) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs of the sequencer: unit operands and handshakes
    always_comb begin
        mul_a            = '0;
        mul_b            = '0;
        div_req.start    = 1'b0;
        div_req.dividend = prod[DIV_W-1:0];
        div_req.divisor  = DIVISOR_K2;
        s_tready         = 1'b0;
        out_load         = 1'b0;
        unique case (state_reg)
            ST_IDLE: s_tready = 1'b1;
            ST_MKP: begin
                mul_a = MUL_A_W'(g_kp);
                mul_b = MUL_B_W'(e_reg);
            end
            ST_MKD: begin
                mul_a = MUL_A_W'(g_kd);
                mul_b = MUL_B_W'(d_reg);
            end
            ST_MEE: begin
                mul_a = MUL_A_W'(e_reg);
                mul_b = MUL_B_W'(e_reg);
            end
            ST_MK2: begin
                mul_a = prod[MUL_A_W-1:0];
                mul_b = MUL_B_W'(g_k2);
            end
            ST_D10: begin
                div_req.start   = 1'b1;
                div_req.divisor = DIVISOR_K2;
            end
            ST_W10: begin
                mul_a = MUL_A_W'(g_imu);
                mul_b = MUL_B_W'(gyro_reg);
            end
            ST_D100: begin
                div_req.start   = 1'b1;
                div_req.divisor = DIVISOR_IMU;
            end
            ST_MTAN: begin
                mul_a = MUL_A_W'(steer);
                mul_b = TAN_NUM;
            end
            ST_DTAN: begin
                div_req.start   = 1'b1;
                div_req.divisor = DIVISOR_TAN;
            end
            ST_MSC: begin
                mul_a = MUL_A_W'(ack_reg);
                mul_b = MUL_B_W'(tan_reg);
            end
            ST_DSC: begin
                div_req.start   = 1'b1;
                div_req.divisor = DIVISOR_SCALE;
            end
            ST_MDL: begin
                mul_a = MUL_A_W'(speed_reg);
                mul_b = scale_reg;
            end
            ST_DDL: begin
                div_req.start   = 1'b1;
                div_req.divisor = DIVISOR_DELTA;
            end
            ST_DPWM: begin
                div_req.start    = 1'b1;
                div_req.dividend = DIV_W'(angle_reg);
                div_req.divisor  = DIVISOR_PWM;
            end
            ST_FIN: out_load = !m_tvalid_reg || m_tready;
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            prev_err_reg <= '0;
            prev_seq_reg <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (accept && frame_ok) begin
                prev_err_reg <= in_err;
                prev_seq_reg <= in_seq;
            end
            if (out_load)      m_tvalid_reg <= 1'b1;
            else if (m_tready) m_tvalid_reg <= 1'b0;
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        if (accept && frame_ok) begin
            e_reg     <= in_err;
            d_reg     <= in_err - prev_err_reg;
            gyro_reg  <= in_yaw;
            gains_reg <= gains_sel;
            ack_reg   <= ack_sel;
            speed_reg <= speed_sel;
        end
        case (state_reg)
            ST_MKD: acc_reg <= prod[15:0];
            ST_MEE: acc_reg <= acc_reg + prod[15:0];
            ST_W10: begin
                if (div_rsp.done) begin
                    if (e_reg[15]) acc_reg <= acc_reg - div_rsp.quotient[15:0];
                    else           acc_reg <= acc_reg + div_rsp.quotient[15:0];
                end
            end
            ST_W100: if (div_rsp.done) acc_reg <= acc_reg - div_rsp.quotient[15:0];
            ST_ANG:  angle_reg <= clamped_angle;
            ST_WTAN: if (div_rsp.done) tan_reg <= div_rsp.quotient[15:0];
            ST_WSC:  if (div_rsp.done) scale_reg <= div_rsp.quotient[23:0];
            ST_WDL:  if (div_rsp.done) delta_reg <= div_rsp.quotient[15:0];
            ST_WPWM: if (div_rsp.done) pwm_reg <= div_rsp.quotient[14:0] + PWM_OFFSET;
            default: ;
        endcase
        if (out_load) begin
            m_tdata_reg <= {1'b0, right_speed, left_speed, pwm_reg, angle_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

/* test/testbench.sv */
`timescale 1ns / 1ps

module testbench;
    import pdsd_pkg::*;

    localparam int HALF_PERIOD   = 10;
    localparam int RESET_CYCLES  = 10;
    localparam int SETTLE_CYCLES = 120;   // idle wait after the last result of a phase
    localparam int STALL_LIMIT   = 4000;  // cycles with no transaction on any channel
    localparam int PHASE_FRAMES  = 290;
    localparam int HOLD_AFTER    = 500;   // results seen before the long receiver hold-off
    localparam int HOLD_CYCLES   = 600;

    // flavors of register settings for the random phases
    typedef enum int {
        CFG_MILD,
        CFG_WILD,
        CFG_CORNER,
        CFG_SWAPPED
    } cfg_style_t;

    // input transaction, lowest field in the lowest bits
    typedef struct packed {
        logic [2:0]         pad;
        logic               stop_request;
        logic               on_ramp;
        logic               in_ring;
        logic               on_straight;
        logic [15:0]        frame_seq;
        logic               frame_ready;
        logic signed [15:0] yaw_rate;
        logic signed [15:0] lateral_error;
    } frame_t;

    // result transaction, lowest field in the lowest bits
    typedef struct packed {
        logic               pad;
        logic signed [15:0] right_speed;
        logic signed [15:0] left_speed;
        logic signed [14:0] pwm_duty;
        logic signed [15:0] steer_angle;
    } drive_cmd_t;

    // steering and wheel speed predictor with its result queue
    class steer_scoreboard;
        logic [63:0]  gain_set [3];  // straight, left, normal
        logic [63:0]  ack_word;
        logic [63:0]  speed_word;
        longint       center;
        longint       lo_limit;
        longint       hi_limit;
        longint       last_error;
        logic [15:0]  last_seq;
        drive_cmd_t   queued_cmds[$];
        int           errors;

        function new();
            foreach (gain_set[i]) gain_set[i] = '0;
            ack_word   = '0;
            speed_word = '0;
            center     = 0;
            lo_limit   = -32768;
            hi_limit   = 32767;
            last_error = 0;
            last_seq   = '0;
            errors     = 0;
        endfunction

        static function longint wrap16(longint v);
            logic signed [15:0] w;
            w = v[15:0];
            return w;
        endfunction

        static function longint field16(logic [63:0] word, int idx);
            logic signed [15:0] w;
            w = word[16*idx +: 16];
            return w;
        endfunction

        function void set_register(cfg_idx_t idx, logic [63:0] value);
            case (idx)
                CFG_GAINS_STRAIGHT: gain_set[0] = value;
                CFG_GAINS_LEFT:     gain_set[1] = value;
                CFG_GAINS_NORMAL:   gain_set[2] = value;
                CFG_ACKERMANN:      ack_word = value & 64'h0000_FFFF_FFFF_FFFF;
                CFG_SPEED:          speed_word = value;
                CFG_ANGLE_CENTER:   center = wrap16(value);
                CFG_ANGLE_MIN:      lo_limit = wrap16(value);
                CFG_ANGLE_MAX:      hi_limit = wrap16(value);
                default: ;
            endcase
        endfunction

        function int pending();
            return queued_cmds.size();
        endfunction

        // work out the command for one accepted frame, if it is not skipped
        function void predict_frame(frame_t f);
            longint      e, gyro, d, k2term, sum, ctrl, angle, speed;
            longint      steer, tanv, scale, delta, left, right;
            logic [63:0] gains;
            int          sel;
            drive_cmd_t  cmd;

            if (!f.frame_ready || f.frame_seq == last_seq) return;
            last_seq = f.frame_seq;

            e    = f.lateral_error;
            gyro = f.yaw_rate;
            d    = wrap16(e - last_error);

            // gain set and ackermann factor share the same selection
            if (f.on_straight && !f.in_ring && !f.on_ramp) sel = 0;
            else if (e < 0) sel = 1;
            else sel = 2;
            gains = gain_set[sel];

            k2term = field16(gains, 2) * e * e / 10;
            sum = field16(gains, 0) * e + field16(gains, 1) * d;
            sum = (e >= 0) ? sum + k2term : sum - k2term;
            sum = sum - field16(gains, 3) * gyro / 100;
            ctrl = wrap16(sum);
            last_error = e;

            // wrap first, then clamp; with inverted limits the lower limit is checked first and wins
            angle = wrap16(center - ctrl);
            if (angle < lo_limit) angle = lo_limit;
            else if (angle > hi_limit) angle = hi_limit;

            if (f.stop_request) speed = 0;
            else if (f.on_ramp) speed = field16(speed_word, 0);
            else if (f.in_ring) speed = field16(speed_word, 1);
            else if (f.on_straight) speed = field16(speed_word, 2);
            else speed = field16(speed_word, 3);

            // ackermann slowdown of the inner wheel
            steer = wrap16(center - angle);
            tanv  = steer * 175 / 1000;
            scale = field16(ack_word, sel) * tanv / 100;
            delta = wrap16(speed * scale / 10000);
            if (delta <= 0) begin
                left  = wrap16(speed + delta);
                right = speed;
            end else begin
                left  = speed;
                right = wrap16(speed - delta);
            end

            cmd             = '0;
            cmd.steer_angle = 16'(angle);
            cmd.pwm_duty    = 15'(angle / 3 + 1500);
            cmd.left_speed  = 16'(left);
            cmd.right_speed = 16'(right);
            queued_cmds.push_back(cmd);
        endfunction

        function void compare_field(string name, longint want, longint got);
            if (want != got) begin
                $error("%s: expected %0d, actual %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(drive_cmd_t got);
            drive_cmd_t want;
            if (queued_cmds.size() == 0) begin
                $error("result %h arrived with no frame outstanding", got);
                errors++;
                return;
            end
            want = queued_cmds.pop_front();
            if ($isunknown(got[62:0])) begin
                $error("result carries unknown bits: %h", got);
                errors++;
            end
            compare_field("steer_angle", want.steer_angle, got.steer_angle);
            compare_field("pwm_duty", want.pwm_duty, got.pwm_duty);
            compare_field("left_speed", want.left_speed, got.left_speed);
            compare_field("right_speed", want.right_speed, got.right_speed);
        endfunction
    endclass

    logic               aclk      = 1'b0;
    logic               aresetn   = 1'b0;
    logic               s_tvalid  = 1'b0;
    logic               s_tready;
    frame_t             s_frame   = '0;
    logic               m_tvalid;
    logic               m_tready  = 1'b0;
    drive_cmd_t         m_cmd;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]   cfg_data  = '0;

    steer_scoreboard    board;
    logic [15:0]        tb_seq        = '0;
    int                 useful_sent   = 0;
    int                 results_seen  = 0;
    int                 idle_cycles   = 0;
    bit                 held_off      = 1'b0;

    steering_pd_with_differential_speed_top DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_frame),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_cmd),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #HALF_PERIOD aclk = ~aclk;

    // transaction monitor and stall watchdog
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) board.predict_frame(s_frame);
            if (m_tvalid && m_tready) begin
                board.check_result(m_cmd);
                results_seen++;
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // result receiver: steady, choppy and stalled stretches, one long hold-off
    initial begin
        int n;
        wait (aresetn === 1'b1);
        forever begin
            if (!held_off && results_seen >= HOLD_AFTER) begin
                held_off = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
            n = $urandom_range(10, 150);
            case ($urandom_range(0, 2))
                0: repeat (n) begin
                    m_tready <= 1'b1;
                    @(posedge aclk);
                end
                1: repeat (n) begin
                    m_tready <= ($urandom_range(0, 3) != 0);
                    @(posedge aclk);
                end
                default: begin
                    m_tready <= 1'b0;
                    repeat ($urandom_range(1, 30)) @(posedge aclk);
                end
            endcase
        end
    end

    // register write; valid stays high for back-to-back writes
    task automatic write_reg(input cfg_idx_t idx, input logic [63:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        board.set_register(idx, value);
    endtask

    task automatic load_config(input logic [63:0] g_st, g_lt, g_nm, ack, spd,
                               input logic [63:0] ctr, lo, hi);
        write_reg(CFG_GAINS_STRAIGHT, g_st);
        write_reg(CFG_GAINS_LEFT, g_lt);
        write_reg(CFG_GAINS_NORMAL, g_nm);
        write_reg(CFG_ACKERMANN, ack);
        write_reg(CFG_SPEED, spd);
        write_reg(CFG_ANGLE_CENTER, ctr);
        write_reg(CFG_ANGLE_MIN, lo);
        write_reg(CFG_ANGLE_MAX, hi);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_frame(input frame_t f);
        s_tvalid <= 1'b1;
        s_frame  <= f;
        do @(posedge aclk); while (!s_tready);
    endtask

    // wait for every outstanding result, then let the block go idle
    task automatic drain();
        @(posedge aclk);
        while (board.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    function automatic frame_t frame_of(int e, int yaw, bit rdy, int seq,
                                        bit st, bit ring, bit ramp, bit stop);
        frame_t f;
        f               = '0;
        f.lateral_error = 16'(e);
        f.yaw_rate      = 16'(yaw);
        f.frame_ready   = rdy;
        f.frame_seq     = 16'(seq);
        f.on_straight   = st;
        f.in_ring       = ring;
        f.on_ramp       = ramp;
        f.stop_request  = stop;
        if (rdy) tb_seq = f.frame_seq;
        return f;
    endfunction

    function automatic logic [15:0] sample16();
        int k;
        k = $urandom_range(0, 9);
        if (k < 6) return 16'(int'($urandom_range(0, 800)) - 400);
        if (k < 8) return 16'(int'($urandom_range(0, 10000)) - 5000);
        return 16'($urandom);
    endfunction

    // mostly consecutive frames, some repeats, not-ready frames and jumps
    function automatic frame_t random_frame();
        frame_t f;
        int     kind;
        f = '0;
        f.frame_ready = 1'b1;
        kind = $urandom_range(0, 99);
        if (kind < 80) f.frame_seq = tb_seq + 16'd1;
        else if (kind < 88) f.frame_seq = tb_seq;
        else if (kind < 94) begin
            f.frame_ready = 1'b0;
            f.frame_seq = 16'($urandom);
        end else f.frame_seq = 16'($urandom);
        if (f.frame_ready) begin
            if (f.frame_seq != tb_seq) useful_sent++;
            tb_seq = f.frame_seq;
        end
        f.lateral_error = sample16();
        f.yaw_rate      = sample16();
        f.on_straight   = $urandom_range(0, 1);
        f.in_ring       = ($urandom_range(0, 3) == 0);
        f.on_ramp       = ($urandom_range(0, 6) == 0);
        f.stop_request  = ($urandom_range(0, 9) == 0);
        return f;
    endfunction

    function automatic logic [15:0] pick16(cfg_style_t style, int span);
        if (style == CFG_WILD) return 16'($urandom);
        if (style == CFG_CORNER) begin
            case ($urandom_range(0, 4))
                0: return 16'h8000;
                1: return 16'h7FFF;
                2: return 16'hFFFF;
                3: return 16'h0000;
                default: return 16'h0001;
            endcase
        end
        return 16'(int'($urandom_range(0, 2 * span)) - span);
    endfunction

    task automatic random_config(input cfg_style_t style);
        logic [63:0] g [3];
        logic [63:0] ack, spd, ctr, lo, hi;
        int          c, reach;
        foreach (g[i]) begin
            if (style == CFG_WILD) g[i] = {$urandom, $urandom};
            else g[i] = {pick16(style, 60), pick16(style, 8),
                         pick16(style, 40), pick16(style, 40)};
        end
        if (style == CFG_WILD) begin
            ack = {$urandom, $urandom};
            spd = {$urandom, $urandom};
            ctr = {$urandom, $urandom};
            lo  = {$urandom, $urandom};
            hi  = {$urandom, $urandom};
        end else begin
            ack = {16'h0, pick16(style, 300), pick16(style, 300), pick16(style, 300)};
            spd = {pick16(style, 8000), pick16(style, 8000),
                   pick16(style, 8000), pick16(style, 8000)};
            if (style == CFG_CORNER) begin
                ctr = {48'h0, pick16(style, 0)};
                lo  = {48'h0, pick16(style, 0)};
                hi  = {48'h0, pick16(style, 0)};
            end else begin
                c     = $signed(pick16(style, 3000));
                reach = $urandom_range(1, 8000);
                ctr   = 64'(c);
                // swapped style puts the lower limit above the upper one
                lo    = (style == CFG_SWAPPED) ? 64'(c + reach) : 64'(c - reach);
                hi    = (style == CFG_SWAPPED) ? 64'(c - reach) : 64'(c + reach);
            end
        end
        load_config(g[0], g[1], g[2], ack, spd, ctr, lo, hi);
    endtask

    // main stimulus
    initial begin
        cfg_style_t styles [6];
        int         target, burst, gap;

        styles = '{CFG_MILD, CFG_CORNER, CFG_MILD, CFG_WILD, CFG_SWAPPED, CFG_MILD};
        board = new();
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: one gain set per track case, speed priorities, field extremes
        load_config({16'd10, 16'd1, 16'd3, 16'd2},
                    {16'(-20), 16'd2, 16'd1, 16'd4},
                    {16'd5, 16'd1, 16'd2, 16'd3},
                    {16'h0, 16'(-90), 16'd120, 16'd50},
                    {16'd2000, 16'd3000, 16'd1500, 16'd1000},
                    64'd100, 64'(-2000), 64'd2000);
        send_frame(frame_of(5, 0, 1, 0, 0, 0, 0, 0));          // sequence 0 after reset
        send_frame(frame_of(5, 0, 0, 1, 0, 0, 0, 0));          // not ready
        send_frame(frame_of(100, 50, 1, 1, 0, 0, 0, 0));       // normal set, default speed
        send_frame(frame_of(100, 50, 1, 1, 0, 0, 0, 0));       // repeated sequence
        send_frame(frame_of(-300, -1000, 1, 2, 0, 0, 0, 0));  // left set
        send_frame(frame_of(200, 300, 1, 3, 1, 0, 0, 0));      // straight set
        send_frame(frame_of(-50, 20, 1, 4, 1, 1, 0, 0));       // ring speed
        send_frame(frame_of(50, -20, 1, 5, 1, 0, 1, 0));       // ramp speed
        send_frame(frame_of(-700, 0, 1, 6, 0, 0, 0, 1));       // stop
        send_frame(frame_of(32767, 32767, 1, 7, 0, 0, 0, 0));
        send_frame(frame_of(-32768, -32768, 1, 8, 0, 0, 0, 0));
        send_frame(frame_of(0, 0, 1, 9, 0, 0, 0, 0));
        send_frame(frame_of(-1, -1, 1, 65535, 1, 1, 1, 1));
        send_frame(frame_of(1000, 0, 1, 0, 0, 0, 0, 0));       // sequence 0 now accepted
        send_frame(frame_of(16'h5555, 16'hAAAA, 1, 16'hAAAA, 1, 0, 1, 0));
        send_frame(frame_of(-1234, 16'h5555, 1, 16'h5555, 0, 1, 0, 1));
        s_tvalid <= 1'b0;
        drain();

        // angle wrap past the top of the range
        load_config(64'd1, 64'd1, 64'd1, {16'h0, 16'd100, 16'd100, 16'd100},
                    {16'd5000, 16'd4000, 16'd3000, 16'd2000},
                    64'h7FFF, 64'h8000, 64'h7FFF);
        send_frame(frame_of(-5, 0, 1, 16'h5556, 0, 0, 0, 0));
        send_frame(frame_of(-32768, 0, 1, 16'h5557, 0, 0, 0, 0));
        send_frame(frame_of(100, 0, 1, 16'h5558, 0, 0, 0, 0));
        s_tvalid <= 1'b0;
        drain();

        // lower limit above the upper one
        write_reg(CFG_ANGLE_CENTER, 64'd0);
        write_reg(CFG_ANGLE_MIN, 64'd1000);
        write_reg(CFG_ANGLE_MAX, 64'(-1000));
        cfg_valid <= 1'b0;
        send_frame(frame_of(5000, 0, 1, 16'h5559, 0, 0, 0, 0));
        send_frame(frame_of(-5000, 0, 1, 16'h555A, 0, 0, 0, 0));
        send_frame(frame_of(-300, 0, 1, 16'h555B, 0, 0, 0, 0));
        s_tvalid <= 1'b0;
        drain();

        // random phases, each under fresh register settings
        foreach (styles[p]) begin
            random_config(styles[p]);
            target = useful_sent + PHASE_FRAMES;
            while (useful_sent < target) begin
                burst = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(1, 6);
                repeat (burst) send_frame(random_frame());
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 120);
                if (gap != 0) begin
                    s_tvalid <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
            end
            s_tvalid <= 1'b0;
            drain();
        end

        if (board.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
